// ----- rtl/su_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sort-unique package
// Shared sizes and payload types for the sort-and-remove-duplicates block.
// ----------------------------------------------------------------------------
package su_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [ADDR_W-1:0]        addr_t;
    typedef logic [CNT_W-1:0]         count_t;

endpackage

// ----- rtl/su_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sort-unique input channel
// Valid/ready channel carrying one list element and its end-of-list mark.
// ----------------------------------------------------------------------------
interface su_in_if;

    logic          valid;
    logic          ready;
    su_pkg::data_t value;
    logic          last_item;

    modport source (output valid, output value, output last_item, input ready);
    modport sink   (input valid, input value, input last_item, output ready);

endinterface

// ----- rtl/su_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sort-unique result channel
// Valid/ready channel carrying one distinct value with run flags.
// ----------------------------------------------------------------------------
interface su_out_if;

    logic          valid;
    logic          ready;
    su_pkg::data_t value_res;
    logic          last_result;
    logic          overflowed;

    modport source (output valid, output value_res, output last_result,
                    output overflowed, input ready);
    modport sink   (input valid, input value_res, input last_result,
                    input overflowed, output ready);

endinterface

// ----- rtl/sort_and_remove_duplicates_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sort and remove duplicates
// Collects a list into a sorted store by insertion, then streams out the
// distinct values in ascending order.
//
//   Channel  | Dir | Payload                                   | Role
//   ---------+-----+-------------------------------------------+--------------
//   items    | in  | value, last_item                          | list elements
//   results  | out | value_res, last_result, overflowed        | distinct vals
//
// An element is inserted by moving each stored entry larger than it up one
// place, each move being one read and one write of the store, which has one
// read port and one write port; the element then lands in the freed entry.
// A full store drops the element and sets the overflow flag.
// After the last element, emission reads the largest entry (S_EMIT_MAXRD,
// S_EMIT_MAXCAP), then steps through the entries in order, skipping repeats,
// with each result held until results takes it.
// items.ready is high only while the block waits for an element.
// Reset clears count, overflow flag and sequencer; the store needs no clearing.
// ----------------------------------------------------------------------------
module sort_and_remove_duplicates_top
(
    input  logic      clk,
    input  logic      rst_n,
    su_in_if.sink     items,
    su_out_if.source  results
);

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_EMIT_MAXRD,
        S_EMIT_MAXCAP,
        S_EMIT_CHK,
        S_OUT
    } state_t;

    localparam su_pkg::count_t CAP_CNT = su_pkg::CNT_W'(su_pkg::CAPACITY);

    state_t          state_reg, state_next;
    su_pkg::addr_t   pos_reg, pos_next;
    su_pkg::addr_t   idx_reg, idx_next;
    su_pkg::count_t  count_reg, count_next;
    logic            ovf_reg, ovf_next;
    logic            last_reg, last_next;
    logic            have_prev_reg, have_prev_next;
    su_pkg::data_t   val_reg, val_next;
    su_pkg::data_t   max_reg, max_next;
    su_pkg::data_t   prev_reg, prev_next;
    su_pkg::data_t   out_val_reg, out_val_next;
    logic            out_last_reg, out_last_next;
    logic            out_ovf_reg, out_ovf_next;

    su_pkg::data_t   store_mem [su_pkg::CAPACITY];
    su_pkg::data_t   rd_data_reg;
    su_pkg::addr_t   rd_addr;
    logic            mem_we;
    su_pkg::addr_t   mem_wa;
    su_pkg::data_t   mem_wd;

    assign items.ready         = (state_reg == S_IDLE);
    assign results.valid       = (state_reg == S_OUT);
    assign results.value_res   = out_val_reg;
    assign results.last_result = out_last_reg;
    assign results.overflowed  = out_ovf_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        last_next      = last_reg;
        have_prev_next = have_prev_reg;
        val_next       = val_reg;
        max_next       = max_reg;
        prev_next      = prev_reg;
        out_val_next   = out_val_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        mem_we         = 1'b0;
        mem_wa         = pos_reg;
        mem_wd         = val_reg;
        rd_addr        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (items.valid)
                begin
                    val_next  = items.value;
                    last_next = items.last_item;
                    if (count_reg != CAP_CNT)
                    begin
                        pos_next   = count_reg[su_pkg::ADDR_W-1:0];
                        state_next = S_INS_RD;
                    end
                    else
                    begin
                        ovf_next   = 1'b1;
                        state_next = items.last_item ? S_EMIT_MAXRD : S_IDLE;
                    end
                end
            end
            S_INS_RD:
            begin
                if (pos_reg == '0)
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                    state_next = last_reg ? S_EMIT_MAXRD : S_IDLE;
                end
                else
                begin
                    rd_addr    = pos_reg - 1'b1;
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                mem_we = 1'b1;
                if (rd_data_reg > val_reg)
                begin
                    // shift the larger entry up one place
                    mem_wd     = rd_data_reg;
                    pos_next   = pos_reg - 1'b1;
                    state_next = S_INS_RD;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    state_next = last_reg ? S_EMIT_MAXRD : S_IDLE;
                end
            end
            S_EMIT_MAXRD:
            begin
                rd_addr    = su_pkg::ADDR_W'(count_reg - 1'b1);
                state_next = S_EMIT_MAXCAP;
            end
            S_EMIT_MAXCAP:
            begin
                max_next       = rd_data_reg;
                idx_next       = '0;
                have_prev_next = 1'b0;
                state_next     = S_EMIT_CHK;
            end
            S_EMIT_CHK:
            begin
                if (have_prev_reg && (rd_data_reg == prev_reg))
                begin
                    idx_next = idx_reg + 1'b1;
                    rd_addr  = idx_reg + 1'b1;
                end
                else
                begin
                    out_val_next   = rd_data_reg;
                    out_last_next  = (rd_data_reg == max_reg);
                    out_ovf_next   = ovf_reg;
                    prev_next      = rd_data_reg;
                    have_prev_next = 1'b1;
                    state_next     = S_OUT;
                end
            end
            S_OUT:
            begin
                if (results.ready)
                begin
                    if (out_last_reg)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        rd_addr    = idx_reg + 1'b1;
                        state_next = S_EMIT_CHK;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            have_prev_reg <= 1'b0;
            last_reg      <= 1'b0;
            pos_reg       <= '0;
            idx_reg       <= '0;
            out_last_reg  <= 1'b0;
            out_ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            have_prev_reg <= have_prev_next;
            last_reg      <= last_next;
            pos_reg       <= pos_next;
            idx_reg       <= idx_next;
            out_last_reg  <= out_last_next;
            out_ovf_reg   <= out_ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg     <= val_next;
        max_reg     <= max_next;
        prev_reg    <= prev_next;
        out_val_reg <= out_val_next;
    end

endmodule

// ----- rtl/su_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sort-unique port checker
// Watches the block's channels for sequencing and handshake slips.
// ----------------------------------------------------------------------------
module su_checker
(
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          in_last,
    input logic          out_valid,
    input logic          out_ready,
    input su_pkg::data_t out_value,
    input logic          out_last
);

    // never take an element while a result waits
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("element taken while a result is pending");

    // a non-final element yields no result in the next cycle
    a_mid_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !in_last) |=> !out_valid)
        else $error("result after a non-final element");

    // the final result ends the run
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_last) |=> (!out_valid && in_ready))
        else $error("run did not end after final result");

    // hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_value)
                                       && $stable(out_last)))
        else $error("stalled result changed");

endmodule

bind sort_and_remove_duplicates_top su_checker u_su_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .in_last   (items.last_item),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_value (results.value_res),
    .out_last  (results.last_result)
);
